// ----- sv/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared widths, operation codes, per-cell data types and the clip helper.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int EXT_W     = PROD_W + 2;
  localparam int QUO_W     = WORD_W + 1;
  localparam int DIV_REM_W = PROD_W;
  localparam int SQ_IN_W   = 2 * QUO_W;
  localparam int SQ_ROOT_W = QUO_W;
  localparam int SQ_REM_W  = QUO_W + 2;
  localparam int STEPS     = QUO_W;
  localparam int FRONT_STAGES = 4;
  localparam int STAGES    = FRONT_STAGES + STEPS + 1 + STEPS + 1;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_SQRT   = 3'd4,
    OP_SQUARE = 3'd5,
    OP_MAG    = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_IN_W-1:0]   n;
  } sq_t;

  typedef struct packed {
    logic [DIV_REM_W-1:0] rem;
    logic [QUO_W-1:0]     bits;
    logic [QUO_W-1:0]     q;
    logic [PROD_W-1:0]    d;
  } div_t;

  typedef struct packed {
    op_t   op;
    word_t x;
    logic  y_neg;
    word_t re;
    word_t im;
    logic  sat;
    logic  dz;
    logic  neg_re;
    logic  neg_im;
    logic  dsat_re;
    logic  dsat_im;
  } side1_t;

  typedef struct packed {
    op_t   op;
    logic  y_neg;
    word_t re;
    word_t im;
    logic  sat;
    logic  dz;
  } side2_t;

  // Clip a wide signed value to the word range; the top bit of the result
  // flags that clipping happened.
  function automatic logic [WORD_W:0] clip_word(input logic signed [EXT_W-1:0] v);
    logic              in_range;
    logic [WORD_W-1:0] w;
    in_range = (&v[EXT_W-1:WORD_W-1]) | ~(|v[EXT_W-1:WORD_W-1]);
    if (in_range) begin
      w = v[WORD_W-1:0];
    end else if (v[EXT_W-1]) begin
      w = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      w = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return {~in_range, w};
  endfunction

endpackage

// ----- sv/cau_front.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Input register, product stage, sum and rounding stage, and the stage that
// loads the divider and square-root cell chains.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0]          op,
  input  logic signed [31:0]  first_real,
  input  logic signed [31:0]  first_imag,
  input  logic signed [31:0]  second_real,
  input  logic signed [31:0]  second_imag,
  output cau_pkg::sq_t        sq_out,
  output cau_pkg::div_t       dre_out,
  output cau_pkg::div_t       dim_out,
  output cau_pkg::side1_t     side_out
);

  // Stage A: input capture.
  cau_pkg::op_t  op_a;
  cau_pkg::word_t x_a, y_a, c_a, e_a;

  // Stage B: products.
  cau_pkg::op_t  op_b;
  cau_pkg::word_t x_b, y_b, c_b, e_b;
  logic signed [cau_pkg::PROD_W-1:0] pr_xc, pr_ye, pr_xe, pr_cy;
  logic signed [cau_pkg::PROD_W-1:0] pr_xx, pr_yy, pr_xy, pr_cc, pr_ee;

  // Stage C: sums.
  cau_pkg::side1_t side_c, side_c_next;
  logic [cau_pkg::PROD_W-1:0] d_c, m1_c, m2_c, nsq_c;
  logic [cau_pkg::PROD_W-1:0] d_c_next, m1_c_next, m2_c_next, nsq_c_next;

  logic signed [cau_pkg::EXT_W-1:0] half_f, half_f1;
  logic signed [cau_pkg::EXT_W-1:0] s1, s2;
  logic [cau_pkg::WORD_W:0] cl_re, cl_im;

  logic [cau_pkg::PROD_W+cau_pkg::FRAC_W-1:0] thr;
  logic dsat1, dsat2;
  cau_pkg::side1_t side_d_next;

  always_ff @(posedge clk) begin
    if (en) begin
      op_a <= cau_pkg::op_t'(op);
      x_a  <= first_real;
      y_a  <= first_imag;
      c_a  <= second_real;
      e_a  <= second_imag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_b  <= op_a;
      x_b   <= x_a;
      y_b   <= y_a;
      c_b   <= c_a;
      e_b   <= e_a;
      pr_xc <= cau_pkg::PROD_W'(x_a) * cau_pkg::PROD_W'(c_a);
      pr_ye <= cau_pkg::PROD_W'(y_a) * cau_pkg::PROD_W'(e_a);
      pr_xe <= cau_pkg::PROD_W'(x_a) * cau_pkg::PROD_W'(e_a);
      pr_cy <= cau_pkg::PROD_W'(c_a) * cau_pkg::PROD_W'(y_a);
      pr_xx <= cau_pkg::PROD_W'(x_a) * cau_pkg::PROD_W'(x_a);
      pr_yy <= cau_pkg::PROD_W'(y_a) * cau_pkg::PROD_W'(y_a);
      pr_xy <= cau_pkg::PROD_W'(x_a) * cau_pkg::PROD_W'(y_a);
      pr_cc <= cau_pkg::PROD_W'(c_a) * cau_pkg::PROD_W'(c_a);
      pr_ee <= cau_pkg::PROD_W'(e_a) * cau_pkg::PROD_W'(e_a);
    end
  end

  always_comb begin
    half_f  = cau_pkg::EXT_W'(1) <<< (cau_pkg::FRAC_W - 1);
    half_f1 = cau_pkg::EXT_W'(1) <<< (cau_pkg::FRAC_W - 2);
    cl_re   = '0;
    cl_im   = '0;
    unique case (op_b)
      cau_pkg::OP_ADD: begin
        cl_re = cau_pkg::clip_word(cau_pkg::EXT_W'(x_b) + cau_pkg::EXT_W'(c_b));
        cl_im = cau_pkg::clip_word(cau_pkg::EXT_W'(y_b) + cau_pkg::EXT_W'(e_b));
      end
      cau_pkg::OP_SUB: begin
        cl_re = cau_pkg::clip_word(cau_pkg::EXT_W'(x_b) - cau_pkg::EXT_W'(c_b));
        cl_im = cau_pkg::clip_word(cau_pkg::EXT_W'(y_b) - cau_pkg::EXT_W'(e_b));
      end
      cau_pkg::OP_MUL: begin
        cl_re = cau_pkg::clip_word((cau_pkg::EXT_W'(pr_xc) - cau_pkg::EXT_W'(pr_ye)
                                    + half_f) >>> cau_pkg::FRAC_W);
        cl_im = cau_pkg::clip_word((cau_pkg::EXT_W'(pr_xe) + cau_pkg::EXT_W'(pr_cy)
                                    + half_f) >>> cau_pkg::FRAC_W);
      end
      cau_pkg::OP_SQUARE: begin
        cl_re = cau_pkg::clip_word((cau_pkg::EXT_W'(pr_xx) - cau_pkg::EXT_W'(pr_yy)
                                    + half_f) >>> cau_pkg::FRAC_W);
        cl_im = cau_pkg::clip_word((cau_pkg::EXT_W'(pr_xy) + half_f1)
                                   >>> (cau_pkg::FRAC_W - 1));
      end
      default: begin
        cl_re = '0;
        cl_im = '0;
      end
    endcase

    // Divider numerators: magnitude and sign of a * conj(b).
    s1 = cau_pkg::EXT_W'(pr_xc) + cau_pkg::EXT_W'(pr_ye);
    s2 = cau_pkg::EXT_W'(pr_cy) - cau_pkg::EXT_W'(pr_xe);
    m1_c_next  = cau_pkg::PROD_W'(s1[cau_pkg::EXT_W-1] ? -s1 : s1);
    m2_c_next  = cau_pkg::PROD_W'(s2[cau_pkg::EXT_W-1] ? -s2 : s2);
    d_c_next   = pr_cc + pr_ee;
    nsq_c_next = pr_xx + pr_yy;

    side_c_next.op      = op_b;
    side_c_next.x       = x_b;
    side_c_next.y_neg   = y_b[cau_pkg::WORD_W-1];
    side_c_next.re      = cl_re[cau_pkg::WORD_W-1:0];
    side_c_next.im      = cl_im[cau_pkg::WORD_W-1:0];
    side_c_next.sat     = cl_re[cau_pkg::WORD_W] | cl_im[cau_pkg::WORD_W];
    side_c_next.dz      = (op_b == cau_pkg::OP_DIV) && (d_c_next == '0);
    side_c_next.neg_re  = s1[cau_pkg::EXT_W-1];
    side_c_next.neg_im  = s2[cau_pkg::EXT_W-1];
    side_c_next.dsat_re = 1'b0;
    side_c_next.dsat_im = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_c <= side_c_next;
      d_c    <= d_c_next;
      m1_c   <= m1_c_next;
      m2_c   <= m2_c_next;
      nsq_c  <= nsq_c_next;
    end
  end

  // Stage D: the quotient overflows when the numerator reaches
  // (2^integer_bits + 1) times the divisor.
  always_comb begin
    thr   = ({cau_pkg::FRAC_W'(0), d_c} << cau_pkg::FRAC_W) + {cau_pkg::FRAC_W'(0), d_c};
    dsat1 = {cau_pkg::FRAC_W'(0), m1_c} >= thr;
    dsat2 = {cau_pkg::FRAC_W'(0), m2_c} >= thr;
    side_d_next         = side_c;
    side_d_next.dsat_re = dsat1;
    side_d_next.dsat_im = dsat2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out     <= side_d_next;
      dre_out.rem  <= m1_c >> (cau_pkg::QUO_W - cau_pkg::FRAC_W);
      dre_out.bits <= {m1_c[cau_pkg::QUO_W-cau_pkg::FRAC_W-1:0], cau_pkg::FRAC_W'(0)};
      dre_out.q    <= '0;
      dre_out.d    <= d_c;
      dim_out.rem  <= m2_c >> (cau_pkg::QUO_W - cau_pkg::FRAC_W);
      dim_out.bits <= {m2_c[cau_pkg::QUO_W-cau_pkg::FRAC_W-1:0], cau_pkg::FRAC_W'(0)};
      dim_out.q    <= '0;
      dim_out.d    <= d_c;
      sq_out.rem   <= '0;
      sq_out.root  <= '0;
      sq_out.n     <= cau_pkg::SQ_IN_W'(nsq_c);
    end
  end

endmodule

// ----- sv/cau_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: brings in one dividend bit, makes one
// quotient bit and passes the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module cau_div_cell (
  input  logic          clk,
  input  logic          en,
  input  cau_pkg::div_t cur,
  output cau_pkg::div_t nxt
);

  logic [cau_pkg::DIV_REM_W:0] rem2;
  logic [cau_pkg::DIV_REM_W:0] diff;
  logic                        take;

  always_comb begin
    rem2 = {cur.rem, cur.bits[cau_pkg::QUO_W-1]};
    diff = rem2 - {1'b0, cur.d};
    take = rem2 >= {1'b0, cur.d};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nxt.d    <= cur.d;
      nxt.bits <= {cur.bits[cau_pkg::QUO_W-2:0], 1'b0};
      nxt.q    <= {cur.q[cau_pkg::QUO_W-2:0], take};
      nxt.rem  <= take ? diff[cau_pkg::DIV_REM_W-1:0] : rem2[cau_pkg::DIV_REM_W-1:0];
    end
  end

endmodule

// ----- sv/cau_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square-root cell
// One digit-by-digit integer square-root step: takes two radicand bits and
// makes one root bit.
// ----------------------------------------------------------------------------
module cau_sqrt_cell (
  input  logic         clk,
  input  logic         en,
  input  cau_pkg::sq_t cur,
  output cau_pkg::sq_t nxt
);

  logic [cau_pkg::SQ_REM_W+1:0] rem2;
  logic [cau_pkg::SQ_REM_W+1:0] trial;
  logic [cau_pkg::SQ_REM_W+1:0] diff;
  logic                         take;

  always_comb begin
    rem2  = {cur.rem, cur.n[cau_pkg::SQ_IN_W-1 -: 2]};
    trial = (cau_pkg::SQ_REM_W + 2)'({cur.root, 2'b01});
    diff  = rem2 - trial;
    take  = rem2 >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nxt.n    <= {cur.n[cau_pkg::SQ_IN_W-3:0], 2'b00};
      nxt.root <= {cur.root[cau_pkg::SQ_ROOT_W-2:0], take};
      nxt.rem  <= take ? diff[cau_pkg::SQ_REM_W-1:0] : rem2[cau_pkg::SQ_REM_W-1:0];
    end
  end

endmodule

// ----- sv/cau_fixup.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit middle stage
// Rounds and clips the quotients, clips the magnitude and loads the two
// square-root chains of the principal root.
// ----------------------------------------------------------------------------
module cau_fixup (
  input  logic            clk,
  input  logic            en,
  input  cau_pkg::sq_t    mag_in,
  input  cau_pkg::div_t   dre_in,
  input  cau_pkg::div_t   dim_in,
  input  cau_pkg::side1_t side_in,
  output cau_pkg::sq_t    sqa_out,
  output cau_pkg::sq_t    sqb_out,
  output cau_pkg::side2_t side_out
);

  logic [cau_pkg::WORD_W:0] q_re, q_im, cl_mag;
  logic signed [cau_pkg::QUO_W+1:0] sum_p, sum_m;
  cau_pkg::side2_t side_next;

  // Round to nearest with ties away from zero, apply the sign and clip.
  function automatic logic [cau_pkg::WORD_W:0] div_finish(input cau_pkg::div_t dv,
                                                          input logic neg,
                                                          input logic dsat);
    logic [cau_pkg::QUO_W:0]          qr;
    logic signed [cau_pkg::EXT_W-1:0] v;
    qr = {1'b0, dv.q} + (cau_pkg::QUO_W + 1)'({dv.rem, 1'b0} >= {1'b0, dv.d});
    v  = cau_pkg::EXT_W'(qr);
    if (neg) begin
      v = -v;
    end
    if (dsat) begin
      return neg ? {1'b1, 1'b1, (cau_pkg::WORD_W-1)'(0)}
                 : {1'b1, 1'b0, {(cau_pkg::WORD_W-1){1'b1}}};
    end
    return cau_pkg::clip_word(v);
  endfunction

  always_comb begin
    q_re   = div_finish(dre_in, side_in.neg_re, side_in.dsat_re);
    q_im   = div_finish(dim_in, side_in.neg_im, side_in.dsat_im);
    cl_mag = cau_pkg::clip_word(cau_pkg::EXT_W'(mag_in.root));
    sum_p  = $signed({2'b00, mag_in.root}) + (cau_pkg::QUO_W + 2)'(side_in.x);
    sum_m  = $signed({2'b00, mag_in.root}) - (cau_pkg::QUO_W + 2)'(side_in.x);

    side_next.op    = side_in.op;
    side_next.y_neg = side_in.y_neg;
    side_next.dz    = side_in.dz;
    side_next.re    = side_in.re;
    side_next.im    = side_in.im;
    side_next.sat   = side_in.sat;
    if (side_in.op == cau_pkg::OP_DIV) begin
      if (side_in.dz) begin
        side_next.re  = '0;
        side_next.im  = '0;
        side_next.sat = 1'b0;
      end else begin
        side_next.re  = q_re[cau_pkg::WORD_W-1:0];
        side_next.im  = q_im[cau_pkg::WORD_W-1:0];
        side_next.sat = q_re[cau_pkg::WORD_W] | q_im[cau_pkg::WORD_W];
      end
    end else if (side_in.op == cau_pkg::OP_MAG) begin
      side_next.re  = cl_mag[cau_pkg::WORD_W-1:0];
      side_next.im  = '0;
      side_next.sat = cl_mag[cau_pkg::WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out     <= side_next;
      sqa_out.rem  <= '0;
      sqa_out.root <= '0;
      sqa_out.n    <= cau_pkg::SQ_IN_W'(sum_p[cau_pkg::QUO_W:0]) << (cau_pkg::FRAC_W - 1);
      sqb_out.rem  <= '0;
      sqb_out.root <= '0;
      sqb_out.n    <= cau_pkg::SQ_IN_W'(sum_m[cau_pkg::QUO_W:0]) << (cau_pkg::FRAC_W - 1);
    end
  end

endmodule

// ----- sv/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, square root, square and magnitude of
// complex numbers in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// While the output is not stalled, the unit takes one word per clock and
// gives one result word per clock, so independent operand pairs stream
// through at full rate. Every operation passes through the same stages
// from acceptance to the result being offered: four front stages (input
// register, products, sums, chain load), a chain of 33 cells that each make
// one quotient bit of both divider lanes and one bit of the magnitude root,
// one fix-up stage, a second chain of 33 cells that each make one bit of the
// two roots of the principal square root, and the output register. The whole
// pipeline advances together; while a result waits at the output it holds,
// and in_ready drops. A divide by zero gives a zero result with
// divide_by_zero set; any part that leaves the Q16.16 range is clipped and
// flags saturated. Opcode 7 gives a zero result with both flags low.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic signed [31:0] first_real,
  input  logic signed [31:0] first_imag,
  input  logic signed [31:0] second_real,
  input  logic signed [31:0] second_imag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_real,
  output logic signed [31:0] result_imag,
  output logic               divide_by_zero,
  output logic               saturated
);

  logic adv;
  logic [cau_pkg::STAGES-1:0] vld;

  // Chain one carries the divider lanes, the magnitude root and side data.
  cau_pkg::sq_t    mag_ch [0:cau_pkg::STEPS];
  cau_pkg::div_t   dre_ch [0:cau_pkg::STEPS];
  cau_pkg::div_t   dim_ch [0:cau_pkg::STEPS];
  cau_pkg::side1_t s1_ch  [0:cau_pkg::STEPS];

  // Chain two carries the two roots of the principal square root.
  cau_pkg::sq_t    sqa_ch [0:cau_pkg::STEPS];
  cau_pkg::sq_t    sqb_ch [0:cau_pkg::STEPS];
  cau_pkg::side2_t s2_ch  [0:cau_pkg::STEPS];

  logic [cau_pkg::WORD_W:0] cl_r, cl_s;

  // The pipeline moves whenever the output register is empty or drained.
  assign adv       = out_ready || !out_valid;
  assign in_ready  = adv;
  assign out_valid = vld[cau_pkg::STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[cau_pkg::STAGES-2:0], in_valid};
    end
  end

  cau_front u_front (
    .clk         (clk),
    .en          (adv),
    .op          (op),
    .first_real  (first_real),
    .first_imag  (first_imag),
    .second_real (second_real),
    .second_imag (second_imag),
    .sq_out      (mag_ch[0]),
    .dre_out     (dre_ch[0]),
    .dim_out     (dim_ch[0]),
    .side_out    (s1_ch[0])
  );

  for (genvar k = 0; k < cau_pkg::STEPS; k++) begin : g_chain1
    cau_sqrt_cell u_mag (.clk(clk), .en(adv), .cur(mag_ch[k]), .nxt(mag_ch[k+1]));
    cau_div_cell  u_dre (.clk(clk), .en(adv), .cur(dre_ch[k]), .nxt(dre_ch[k+1]));
    cau_div_cell  u_dim (.clk(clk), .en(adv), .cur(dim_ch[k]), .nxt(dim_ch[k+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        s1_ch[k+1] <= s1_ch[k];
      end
    end
  end

  cau_fixup u_fixup (
    .clk      (clk),
    .en       (adv),
    .mag_in   (mag_ch[cau_pkg::STEPS]),
    .dre_in   (dre_ch[cau_pkg::STEPS]),
    .dim_in   (dim_ch[cau_pkg::STEPS]),
    .side_in  (s1_ch[cau_pkg::STEPS]),
    .sqa_out  (sqa_ch[0]),
    .sqb_out  (sqb_ch[0]),
    .side_out (s2_ch[0])
  );

  for (genvar k = 0; k < cau_pkg::STEPS; k++) begin : g_chain2
    cau_sqrt_cell u_sqa (.clk(clk), .en(adv), .cur(sqa_ch[k]), .nxt(sqa_ch[k+1]));
    cau_sqrt_cell u_sqb (.clk(clk), .en(adv), .cur(sqb_ch[k]), .nxt(sqb_ch[k+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        s2_ch[k+1] <= s2_ch[k];
      end
    end
  end

  // The imaginary root takes the sign of the first operand's imaginary part,
  // with zero counted as positive.
  always_comb begin
    cl_r = cau_pkg::clip_word(cau_pkg::EXT_W'(sqa_ch[cau_pkg::STEPS].root));
    if (s2_ch[cau_pkg::STEPS].y_neg) begin
      cl_s = cau_pkg::clip_word(-cau_pkg::EXT_W'(sqb_ch[cau_pkg::STEPS].root));
    end else begin
      cl_s = cau_pkg::clip_word(cau_pkg::EXT_W'(sqb_ch[cau_pkg::STEPS].root));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      divide_by_zero <= s2_ch[cau_pkg::STEPS].dz;
      if (s2_ch[cau_pkg::STEPS].op == cau_pkg::OP_SQRT) begin
        result_real <= cl_r[cau_pkg::WORD_W-1:0];
        result_imag <= cl_s[cau_pkg::WORD_W-1:0];
        saturated   <= cl_r[cau_pkg::WORD_W] | cl_s[cau_pkg::WORD_W];
      end else begin
        result_real <= s2_ch[cau_pkg::STEPS].re;
        result_imag <= s2_ch[cau_pkg::STEPS].im;
        saturated   <= s2_ch[cau_pkg::STEPS].sat;
      end
    end
  end

  // A stalled output freezes every stage of the pipeline.
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(vld))
    else $error("pipeline moved while the output was stalled");

  // A divide by zero always delivers a clean zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_real == 0 && result_imag == 0 && !saturated)
    else $error("divide by zero result is not zero");

  // Nothing reaches the output without having been accepted earlier.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[cau_pkg::STAGES-2]))
    else $error("result appeared without an accepted word");

endmodule
